// ===== src/tbba_pkg.sv =====
`default_nettype none

package tbba_pkg;

  localparam int MAX_BLOCKS       = 1024;
  localparam int ENTRY_W          = 2;
  localparam int ENTRIES_PER_WORD = 16;
  localparam int WORD_W           = ENTRY_W * ENTRIES_PER_WORD;
  localparam int MAP_WORDS        = MAX_BLOCKS / ENTRIES_PER_WORD;
  localparam int WORD_AW          = $clog2(MAP_WORDS);
  localparam int POS_W            = $clog2(ENTRIES_PER_WORD);
  localparam int IDX_W            = 10;
  localparam int CNT_W            = 11;
  localparam int INDEX_LIMIT      = 1024;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(1024);

  localparam logic [ENTRY_W-1:0] ENTRY_ALLOC = 2'b01;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_GET   = 2'd1,
    OP_ALLOC = 2'd2
  } op_e;

  typedef logic [WORD_AW-1:0] word_addr_t;
  typedef logic [WORD_W-1:0]  map_word_t;

  typedef struct packed {
    logic       rd_en;
    word_addr_t rd_addr;
    logic       wr_en;
    word_addr_t wr_addr;
  } map_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
    logic             last;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== src/tbba_map.sv =====
`default_nettype none

module tbba_map (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tbba_pkg::map_ctrl_t  ctrl_i,
  input  tbba_pkg::map_word_t  wr_data_i,
  output tbba_pkg::map_word_t  rd_data_o
);
  import tbba_pkg::*;

  map_word_t        mem_q [MAP_WORDS];
  logic [MAP_WORDS-1:0] row_vld_q;
  map_word_t        rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[ctrl_i.rd_addr];
    end
  end

  // rows never written read as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        row_vld_q[ctrl_i.wr_addr] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= row_vld_q[ctrl_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== src/tbba_scan.sv =====
`default_nettype none

module tbba_scan (
  input  tbba_pkg::map_word_t        word_i,
  input  tbba_pkg::word_addr_t       ptr_i,
  input  wire [tbba_pkg::CNT_W-1:0]  lim_i,
  output tbba_pkg::scan_res_t        res_o
);
  import tbba_pkg::*;

  logic [WORD_AW:0]         wnum;
  logic [WORD_AW:0]         wnext;
  logic [CNT_W-POS_W-1:0]   lim_hi;
  logic [POS_W-1:0]         lim_lo;
  logic [CNT_W-1:0]         next_base;
  logic [ENTRIES_PER_WORD-1:0] elig;

  always_comb begin
    wnum      = {1'b0, ptr_i};
    wnext     = wnum + 1'b1;
    lim_hi    = lim_i[CNT_W-1:POS_W];
    lim_lo    = lim_i[POS_W-1:0];
    next_base = CNT_W'({wnext, {POS_W{1'b0}}});

    for (int k = 0; k < ENTRIES_PER_WORD; k++) begin
      elig[k] = (CNT_W'(wnum) < CNT_W'(lim_hi)) ||
                ((CNT_W'(wnum) == CNT_W'(lim_hi)) && (POS_W'(k) < lim_lo));
    end

    res_o.hit = 1'b0;
    res_o.pos = '0;
    for (int k = ENTRIES_PER_WORD - 1; k >= 0; k--) begin
      if (elig[k] && !word_i[ENTRY_W*k]) begin
        res_o.hit = 1'b1;
        res_o.pos = POS_W'(k);
      end
    end
    res_o.last = (next_base >= lim_i);
  end

endmodule

`default_nettype wire

// ===== src/two_bit_block_bitmap_allocator.sv =====
// Flow: set and get pass from input transfer through the evaluate and respond states to
// result valid; unused codes skip evaluate; allocate stays in evaluate for n map words
// scanned (one 16-entry word per cycle, 1..64). Throughput: one item at a time; next
// item taken the cycle after its result is registered.
// Reset: all blocks read as free at once via per-word valid flags, no clearing pass;
// block_count resets to 1024.
`default_nettype none

module two_bit_block_bitmap_allocator (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [tbba_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [1:0]                    operation_i,
  input  wire [tbba_pkg::IDX_W-1:0]    block_index_i,
  input  wire                          used_in_i,
  input  wire                          inode_in_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         used_out_o,
  output logic                         inode_out_o,
  output logic                         found_o,
  output logic [tbba_pkg::IDX_W-1:0]   allocated_block_o
);
  import tbba_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] lim_q, lim_d;
  logic [1:0]       op_q;
  logic [IDX_W-1:0] idx_q;
  logic             used_q, inode_q;
  word_addr_t       ptr_q, ptr_d;

  logic             res_used_q, res_used_d;
  logic             res_inode_q, res_inode_d;
  logic             res_found_q, res_found_d;
  logic [IDX_W-1:0] res_blk_q, res_blk_d;

  logic             out_valid_q;
  logic             out_used_q, out_inode_q, out_found_q;
  logic [IDX_W-1:0] out_blk_q;

  map_ctrl_t        map_ctrl;
  map_word_t        rd_data;
  map_word_t        wr_data;
  scan_res_t        scan;

  logic             accept;
  logic             out_free;
  logic             in_range;
  logic [POS_W-1:0] ent_pos;
  logic [ENTRY_W-1:0] ent;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_range = {1'b0, idx_q} < CNT_W'(MAX_BLOCKS);
  assign ent_pos  = idx_q[POS_W-1:0];
  assign ent      = rd_data[ENTRY_W*ent_pos +: ENTRY_W];

  tbba_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (map_ctrl),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  tbba_scan u_scan (
    .word_i              (rd_data),
    .ptr_i               (ptr_q),
    .lim_i               (lim_q),
    .res_o               (scan)
  );

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    lim_d       = lim_q;
    res_used_d  = res_used_q;
    res_inode_d = res_inode_q;
    res_found_d = res_found_q;
    res_blk_d   = res_blk_q;
    map_ctrl    = '0;
    wr_data     = rd_data;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_used_d  = 1'b0;
          res_inode_d = 1'b0;
          res_found_d = 1'b0;
          res_blk_d   = '0;
          ptr_d       = '0;
          lim_d       = (cnt_q > CNT_W'(INDEX_LIMIT)) ? CNT_W'(INDEX_LIMIT) : cnt_q;
          if (lim_d > CNT_W'(MAX_BLOCKS)) begin
            lim_d = CNT_W'(MAX_BLOCKS);
          end
          map_ctrl.rd_en   = 1'b1;
          map_ctrl.rd_addr = (op_e'(operation_i) == OP_ALLOC) ? '0
                           : block_index_i[IDX_W-1:POS_W];
          state_d = (operation_i == OP_SET || operation_i == OP_GET ||
                     operation_i == OP_ALLOC) ? ST_EVAL : ST_RESP;
        end
      end
      ST_EVAL: begin
        state_d = ST_RESP;
        case (op_e'(op_q))
          OP_SET: begin
            if (in_range) begin
              map_ctrl.wr_en   = 1'b1;
              map_ctrl.wr_addr = idx_q[IDX_W-1:POS_W];
              wr_data[ENTRY_W*ent_pos +: ENTRY_W] = {inode_q, used_q};
            end
          end
          OP_GET: begin
            if (in_range) begin
              res_used_d  = ent[0];
              res_inode_d = ent[1];
            end
          end
          OP_ALLOC: begin
            if (scan.hit) begin
              map_ctrl.wr_en   = 1'b1;
              map_ctrl.wr_addr = ptr_q;
              wr_data[ENTRY_W*scan.pos +: ENTRY_W] = ENTRY_ALLOC;
              res_found_d = 1'b1;
              res_blk_d   = IDX_W'({ptr_q, scan.pos});
            end else if (!scan.last) begin
              map_ctrl.rd_en   = 1'b1;
              map_ctrl.rd_addr = ptr_q + 1'b1;
              ptr_d   = ptr_q + 1'b1;
              state_d = ST_EVAL;
            end
          end
          default: ;
        endcase
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= BLOCK_COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    lim_q       <= lim_d;
    res_used_q  <= res_used_d;
    res_inode_q <= res_inode_d;
    res_found_q <= res_found_d;
    res_blk_q   <= res_blk_d;
    if (accept) begin
      op_q    <= operation_i;
      idx_q   <= block_index_i;
      used_q  <= used_in_i;
      inode_q <= inode_in_i;
    end
    if (state_q == ST_RESP && out_free) begin
      out_used_q  <= res_used_q;
      out_inode_q <= res_inode_q;
      out_found_q <= res_found_q;
      out_blk_q   <= res_blk_q;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign used_out_o        = out_used_q;
  assign inode_out_o       = out_inode_q;
  assign found_o           = out_found_q;
  assign allocated_block_o = out_blk_q;

`ifndef ASSERT_OFF
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not stalled after transfer");

  a_found_no_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (!used_out_o && !inode_out_o))
    else $error("allocate result carries block bits");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (allocated_block_o == '0))
    else $error("nonzero block index without found");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_ctrl.wr_en |-> (state_q == ST_EVAL && state_d == ST_RESP))
    else $error("map write outside final evaluation");
`endif

endmodule

`default_nettype wire
